/* sv/cbbs_pkg.sv */
// ----------------------------------------------------------------------------
// cbbs_pkg
// shared constants, register indexes and stage types of the blob box tracker
// ----------------------------------------------------------------------------
package cbbs_pkg;

  // frame geometry
  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;

  localparam int COL_W = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
  localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_HEIGHT - 1);

  // width of the steering compare: center plus margin without overflow
  localparam int CMP_W = ((COL_W > 8) ? COL_W : 8) + 1;
  localparam logic [CMP_W-1:0] HALF_WIDTH = CMP_W'(FRAME_WIDTH / 2);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_MARGIN = 3'd6;

  // steering codes
  localparam logic [1:0] STEER_NONE  = 2'd0;
  localparam logic [1:0] STEER_LEFT  = 2'd1;
  localparam logic [1:0] STEER_RIGHT = 2'd2;

  typedef struct packed {
    logic [7:0] blue_low;
    logic [7:0] blue_high;
    logic [7:0] green_low;
    logic [7:0] green_high;
    logic [7:0] red_low;
    logic [7:0] red_high;
    logic [7:0] center_margin;
  } cfg_t;

  // classified pixel handed from the input stage to the tracker
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pix_t;

  typedef struct packed {
    logic       in_range;
    logic       frame_done;
    logic       object_found;
    logic [8:0] box_left;
    logic [8:0] box_right;
    logic [7:0] box_top;
    logic [7:0] box_bottom;
    logic [8:0] center_column;
    logic [1:0] steer;
  } result_t;

endpackage

/* sv/cbbs_classify.sv */
// ----------------------------------------------------------------------------
// cbbs_classify
// input stage: threshold test, raster position counters, pixel register
// ----------------------------------------------------------------------------
module cbbs_classify (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          blue,
  input  logic [7:0]          green,
  input  logic [7:0]          red,
  input  cbbs_pkg::cfg_t      cfg,
  output logic                pix_valid,
  output cbbs_pkg::pix_t      pix,
  input  logic                pix_take
);

  logic [cbbs_pkg::COL_W-1:0] col_count;
  logic [cbbs_pkg::ROW_W-1:0] row_count;
  logic                       accept;
  logic                       hit;
  logic                       at_row_end;
  logic                       at_last;

  assign in_ready = !pix_valid || pix_take;
  assign accept   = in_valid && in_ready;

  assign hit = (blue  >= cfg.blue_low)  && (blue  <= cfg.blue_high) &&
               (green >= cfg.green_low) && (green <= cfg.green_high) &&
               (red   >= cfg.red_low)   && (red   <= cfg.red_high);

  assign at_row_end = (col_count == cbbs_pkg::LAST_COL);
  assign at_last    = at_row_end && (row_count == cbbs_pkg::LAST_ROW);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      pix_valid <= 1'b0;
    end else begin
      if (accept) begin
        pix_valid <= 1'b1;
        if (at_last) begin
          col_count <= '0;
          row_count <= '0;
        end else if (at_row_end) begin
          col_count <= '0;
          row_count <= row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end else if (pix_take) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pix.hit  <= hit;
      pix.last <= at_last;
      pix.col  <= col_count;
      pix.row  <= row_count;
    end
  end

endmodule

/* sv/cbbs_track.sv */
// ----------------------------------------------------------------------------
// cbbs_track
// bounding box tracker, center and steering decision, result register
// ----------------------------------------------------------------------------
module cbbs_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                pix_valid,
  input  cbbs_pkg::pix_t      pix,
  output logic                pix_take,
  input  logic [7:0]          center_margin,
  output logic                out_valid,
  input  logic                out_ready,
  output cbbs_pkg::result_t   result
);

  logic                       seen_any;
  logic [cbbs_pkg::COL_W-1:0] min_column;
  logic [cbbs_pkg::COL_W-1:0] max_column;
  logic [cbbs_pkg::ROW_W-1:0] min_row;
  logic [cbbs_pkg::ROW_W-1:0] max_row;

  logic                       seen_any_next;
  logic [cbbs_pkg::COL_W-1:0] min_column_next;
  logic [cbbs_pkg::COL_W-1:0] max_column_next;
  logic [cbbs_pkg::ROW_W-1:0] min_row_next;
  logic [cbbs_pkg::ROW_W-1:0] max_row_next;

  logic [cbbs_pkg::COL_W-1:0] span;
  logic [cbbs_pkg::COL_W-1:0] center;
  logic [cbbs_pkg::CMP_W-1:0] center_ext;
  logic [cbbs_pkg::CMP_W-1:0] margin_ext;
  logic [1:0]                 steer_code;
  cbbs_pkg::result_t          result_next;

  assign pix_take = pix_valid && (!out_valid || out_ready);

  // box update with the current pixel
  always_comb begin
    seen_any_next   = seen_any;
    min_column_next = min_column;
    max_column_next = max_column;
    min_row_next    = min_row;
    max_row_next    = max_row;
    if (pix.hit) begin
      seen_any_next = 1'b1;
      if (!seen_any) begin
        min_column_next = pix.col;
        max_column_next = pix.col;
        min_row_next    = pix.row;
        max_row_next    = pix.row;
      end else begin
        if (pix.col < min_column) min_column_next = pix.col;
        if (pix.col > max_column) max_column_next = pix.col;
        if (pix.row < min_row)    min_row_next    = pix.row;
        if (pix.row > max_row)    max_row_next    = pix.row;
      end
    end
  end

  assign span       = max_column_next - min_column_next;
  assign center     = min_column_next + (span >> 1);
  assign center_ext = cbbs_pkg::CMP_W'(center);
  assign margin_ext = cbbs_pkg::CMP_W'(center_margin);

  // center < half - margin  <=>  center + margin < half
  always_comb begin
    priority if (center_ext + margin_ext < cbbs_pkg::HALF_WIDTH) begin
      steer_code = cbbs_pkg::STEER_LEFT;
    end else if (center_ext > cbbs_pkg::HALF_WIDTH + margin_ext) begin
      steer_code = cbbs_pkg::STEER_RIGHT;
    end else begin
      steer_code = cbbs_pkg::STEER_NONE;
    end
  end

  always_comb begin
    result_next          = '0;
    result_next.in_range = pix.hit;
    if (pix.last) begin
      result_next.frame_done = 1'b1;
      if (seen_any_next) begin
        result_next.object_found  = 1'b1;
        result_next.box_left      = 9'(min_column_next);
        result_next.box_right     = 9'(max_column_next);
        result_next.box_top       = 8'(min_row_next);
        result_next.box_bottom    = 8'(max_row_next);
        result_next.center_column = 9'(center);
        result_next.steer         = steer_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      seen_any   <= 1'b0;
      min_column <= '0;
      max_column <= '0;
      min_row    <= '0;
      max_row    <= '0;
    end else begin
      if (pix_take) begin
        out_valid <= 1'b1;
        if (pix.last) begin
          seen_any   <= 1'b0;
          min_column <= '0;
          max_column <= '0;
          min_row    <= '0;
          max_row    <= '0;
        end else begin
          seen_any   <= seen_any_next;
          min_column <= min_column_next;
          max_column <= max_column_next;
          min_row    <= min_row_next;
          max_row    <= max_row_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      result <= result_next;
    end
  end

endmodule

/* sv/color_blob_box_steer_top.sv */
// ----------------------------------------------------------------------------
// color_blob_box_steer_top
// color threshold blob tracker: per-pixel mask, frame bounding box and steer
// ----------------------------------------------------------------------------
// usage
//   pixels enter on the in_valid / in_ready channel in raster order, one
//   blue, green, red sample per item; row and column are counted inside
//   every accepted item gives exactly one result item on out_valid /
//   out_ready: the in-range mask bit, plus on the frame's last pixel the
//   frame_done flag, object_found, the box, its center column and steer
//   an item passes the input register, then the result register, before its
//   result is valid; throughput: one item per cycle sustained while out_ready
//   stays high; the limit is the box update plus center and steer compare
//   between the two registers
//   receiver stall: the result register holds, the input register fills,
//   then in_ready drops; nothing is lost or repeated
//   reset: thresholds go to 0..255 on every channel, margin to 12, the
//   raster counters and the box tracker clear, both registers empty
//   configuration: cfg_we writes register cfg_index with cfg_data at once;
//   write only while no item is in flight
// ----------------------------------------------------------------------------
module color_blob_box_steer_top (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [cbbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       blue,
  input  logic [7:0]                       green,
  input  logic [7:0]                       red,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             in_range,
  output logic                             frame_done,
  output logic                             object_found,
  output logic [8:0]                       box_left,
  output logic [8:0]                       box_right,
  output logic [7:0]                       box_top,
  output logic [7:0]                       box_bottom,
  output logic [8:0]                       center_column,
  output logic [1:0]                       steer
);

  cbbs_pkg::cfg_t    cfg;
  cbbs_pkg::pix_t    pix;
  cbbs_pkg::result_t result;
  logic              pix_valid;
  logic              pix_take;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blue_low      <= 8'd0;
      cfg.blue_high     <= 8'd255;
      cfg.green_low     <= 8'd0;
      cfg.green_high    <= 8'd255;
      cfg.red_low       <= 8'd0;
      cfg.red_high      <= 8'd255;
      cfg.center_margin <= 8'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbbs_pkg::REG_BLUE_LOW:      cfg.blue_low      <= cfg_data;
        cbbs_pkg::REG_BLUE_HIGH:     cfg.blue_high     <= cfg_data;
        cbbs_pkg::REG_GREEN_LOW:     cfg.green_low     <= cfg_data;
        cbbs_pkg::REG_GREEN_HIGH:    cfg.green_high    <= cfg_data;
        cbbs_pkg::REG_RED_LOW:       cfg.red_low       <= cfg_data;
        cbbs_pkg::REG_RED_HIGH:      cfg.red_high      <= cfg_data;
        cbbs_pkg::REG_CENTER_MARGIN: cfg.center_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage one: threshold test and raster position
  cbbs_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_take  (pix_take)
  );

  // stage two: box tracking and frame-end report
  cbbs_track u_track (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix           (pix),
    .pix_take      (pix_take),
    .center_margin (cfg.center_margin),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result        (result)
  );

  assign in_range      = result.in_range;
  assign frame_done    = result.frame_done;
  assign object_found  = result.object_found;
  assign box_left      = result.box_left;
  assign box_right     = result.box_right;
  assign box_top       = result.box_top;
  assign box_bottom    = result.box_bottom;
  assign center_column = result.center_column;
  assign steer         = result.steer;

  // box fields only carry data on a frame's last item
  a_mid_frame_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> !object_found && box_left == 9'd0 &&
      box_right == 9'd0 && center_column == 9'd0 &&
      steer == cbbs_pkg::STEER_NONE)
    else $error("box fields set on an item that does not end a frame");

  // an empty frame reports no box and no steering
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done && !object_found |-> box_top == 8'd0 &&
      box_bottom == 8'd0 && center_column == 9'd0 &&
      steer == cbbs_pkg::STEER_NONE)
    else $error("empty frame reports a box or a steer code");

  // the input side only stalls when both stages hold items and the sink stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pix_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule
